// ===== design/allocation_bitmap_find_free_macros.svh =====
// Assertion macros for the allocation bitmap block.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef ALLOCATION_BITMAP_FIND_FREE_MACROS_SVH
`define ALLOCATION_BITMAP_FIND_FREE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define AFZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AFZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/afz_pkg.sv =====
// Shared constants, types and codes for the allocation bitmap block.
// No dependencies.
`timescale 1ns / 1ps

package afz_pkg;

  localparam int MaxSlots  = 256;
  localparam int WordW     = 32;
  localparam int NumWords  = MaxSlots / WordW;
  localparam int WordIdxW  = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int BitIdxW   = $clog2(WordW);
  localparam int CntW      = $clog2(MaxSlots + 1);
  localparam int SlotIdxW  = 8;
  localparam int ModeW     = 2;
  localparam int CfgW      = 9;

  typedef enum logic [ModeW-1:0] {
    MODE_SET   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_FIND  = 2'd3
  } afz_mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } afz_state_e;

  // Word write request into the bitmap store
  typedef struct packed {
    logic                en;
    logic [WordIdxW-1:0] idx;
    logic [WordW-1:0]    data;
  } afz_wr_t;

endpackage

// ===== design/afz_bitmap.sv =====
// Slot bitmap store, organized as words, cleared by reset.
// Depends on afz_pkg.
`timescale 1ns / 1ps

module afz_bitmap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [afz_pkg::WordIdxW-1:0]    rd_idx_i,
  output logic [afz_pkg::WordW-1:0]       rd_word_o,
  input  afz_pkg::afz_wr_t                wr_i
);
  import afz_pkg::*;

  logic [WordW-1:0] words_q [NumWords];

  // Word storage with single write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) begin
        words_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      words_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_word_o = words_q[rd_idx_i];

endmodule

// ===== design/afz_scan.sv =====
// Word scan unit: first clear bit of one bitmap word within the search window.
// Depends on afz_pkg.
`timescale 1ns / 1ps

module afz_scan (
  input  logic [afz_pkg::WordW-1:0]    word_i,
  input  logic [afz_pkg::WordIdxW-1:0] word_idx_i,
  input  logic                         first_i,
  input  logic [afz_pkg::BitIdxW-1:0]  start_bit_i,
  input  logic [afz_pkg::CntW-1:0]     limit_i,
  output logic                         hit_o,
  output logic [afz_pkg::BitIdxW-1:0]  hit_bit_o
);
  import afz_pkg::*;

  localparam int RelW = CntW + 1;

  logic [RelW-1:0]  base;
  logic [RelW-1:0]  rel;
  logic [WordW-1:0] hi_mask;
  logic [WordW-1:0] lo_mask;
  logic [WordW-1:0] cand;

  // Slots at or beyond the limit count as occupied
  always_comb begin
    base = RelW'({word_idx_i, {BitIdxW{1'b0}}});
    rel  = RelW'(limit_i) - base;
    if (rel[RelW-1] || (rel == '0)) begin
      hi_mask = '1;
    end else if (rel >= RelW'(WordW)) begin
      hi_mask = '0;
    end else begin
      hi_mask = ~((WordW'(1) << rel[BitIdxW-1:0]) - WordW'(1));
    end
  end

  // Slots below the start index are skipped in the first word
  assign lo_mask = first_i ? ((WordW'(1) << start_bit_i) - WordW'(1)) : '0;
  assign cand    = word_i | hi_mask | lo_mask;

  // Priority encode lowest zero
  always_comb begin
    hit_o     = 1'b0;
    hit_bit_o = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (!cand[b]) begin
        hit_o     = 1'b1;
        hit_bit_o = BitIdxW'(b);
      end
    end
  end

endmodule

// ===== design/allocation_bitmap_find_free.sv =====
// Allocation bitmap with set, clear, test and find-first-clear operations.
// Depends on afz_pkg, afz_bitmap, afz_scan and the assertion macro header.
// An operation is taken when start is high and busy is low. Set, clear,
// test and any out-of-range index finish in the run state without a scan;
// find scans the bitmap one 32-bit word per cycle through the scan unit,
// one word per step from the start word up to the first clear slot or the
// last word below slot_count. The result is registered onto the result
// ports, marked by done_o for exactly one cycle; the receiver cannot stall
// it, so it must take every result when done_o is high. A new operation may
// be started in the cycle that done_o is shown. The bitmap is cleared by
// reset at once. slot_count may only be written while idle.
`timescale 1ns / 1ps
`include "allocation_bitmap_find_free_macros.svh"

module allocation_bitmap_find_free (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [afz_pkg::ModeW-1:0]     mode_i,
  input  logic [afz_pkg::SlotIdxW-1:0]  slot_index_i,
  // result
  output logic                          done_o,
  output logic                          bit_value_o,
  output logic                          index_valid_o,
  output logic                          found_o,
  output logic [afz_pkg::SlotIdxW-1:0]  found_index_o,
  output logic [afz_pkg::CntW-1:0]      set_total_o,
  output logic                          full_res_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afz_pkg::CfgW-1:0]      cfg_data_i
);
  import afz_pkg::*;

  afz_state_e             state_q, state_d;
  afz_mode_e              mode_q;
  logic [SlotIdxW-1:0]    idx_q;
  logic [WordIdxW-1:0]    word_q, word_d;
  logic                   first_q, first_d;
  logic [CntW-1:0]        tally_q, tally_d;
  logic [CfgW-1:0]        slot_count_q;
  logic                   done_q, done_d;
  logic                   bit_q, bit_d;
  logic                   valid_q, valid_d;
  logic                   found_q, found_d;
  logic [SlotIdxW-1:0]    where_q, where_d;
  logic [CntW-1:0]        total_q;
  logic                   full_q, full_d;

  logic                   accept;
  logic                   finish;
  logic [CntW-1:0]        limit;
  logic                   idx_valid;
  logic [BitIdxW-1:0]     idx_bit;
  logic [WordIdxW-1:0]    last_word;
  logic [WordW-1:0]       rd_word;
  logic                   cur;
  logic                   hit;
  logic [BitIdxW-1:0]     hit_bit;
  afz_wr_t                wr;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Effective slot count saturates at the bitmap size
  assign limit = (CntW'(slot_count_q) > CntW'(MaxSlots)) ? CntW'(MaxSlots)
                                                          : CntW'(slot_count_q);
  assign idx_valid = CntW'(idx_q) < limit;
  assign idx_bit   = idx_q[BitIdxW-1:0];
  assign last_word = WordIdxW'((limit - CntW'(1)) >> BitIdxW);
  assign cur       = rd_word[idx_bit];

  afz_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (word_q),
    .rd_word_o (rd_word),
    .wr_i      (wr)
  );

  afz_scan u_scan (
    .word_i      (rd_word),
    .word_idx_i  (word_q),
    .first_i     (first_q),
    .start_bit_i (idx_bit),
    .limit_i     (limit),
    .hit_o       (hit),
    .hit_bit_o   (hit_bit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (finish) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operation and scan step outputs
  always_comb begin
    finish  = 1'b0;
    word_d  = word_q;
    first_d = first_q;
    tally_d = tally_q;
    bit_d   = 1'b0;
    valid_d = idx_valid;
    found_d = 1'b0;
    where_d = '0;
    wr.en   = 1'b0;
    wr.idx  = word_q;
    wr.data = rd_word;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_d  = WordIdxW'(slot_index_i >> BitIdxW);
          first_d = 1'b1;
        end
      end
      ST_RUN: begin
        if (!idx_valid) begin
          finish = 1'b1;
        end else begin
          unique case (mode_q)
            MODE_SET: begin
              finish = 1'b1;
              bit_d  = cur;
              if (!cur) begin
                wr.en            = 1'b1;
                wr.data[idx_bit] = 1'b1;
                tally_d          = tally_q + CntW'(1);
              end
            end
            MODE_CLEAR: begin
              finish = 1'b1;
              bit_d  = cur;
              if (cur) begin
                wr.en            = 1'b1;
                wr.data[idx_bit] = 1'b0;
                tally_d          = tally_q - CntW'(1);
              end
            end
            MODE_TEST: begin
              finish = 1'b1;
              bit_d  = cur;
            end
            MODE_FIND: begin
              first_d = 1'b0;
              if (hit) begin
                finish  = 1'b1;
                found_d = 1'b1;
                where_d = SlotIdxW'({word_q, hit_bit});
              end else if (word_q == last_word) begin
                finish = 1'b1;
              end else begin
                word_d = word_q + WordIdxW'(1);
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      default: finish = 1'b1;
    endcase
    done_d = (state_q == ST_RUN) && finish;
    full_d = tally_d >= limit;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tally_q      <= '0;
      slot_count_q <= CfgW'(MaxSlots);
      done_q       <= 1'b0;
      first_q      <= 1'b0;
      word_q       <= '0;
    end else begin
      state_q <= state_d;
      tally_q <= tally_d;
      done_q  <= done_d;
      first_q <= first_d;
      word_q  <= word_d;
      if (cfg_valid_i && cfg_ready_o) slot_count_q <= cfg_data_i;
    end
  end

  // Command capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= afz_mode_e'(mode_i);
      idx_q  <= slot_index_i;
    end
    if (done_d) begin
      bit_q   <= bit_d;
      valid_q <= valid_d;
      found_q <= found_d;
      where_q <= where_d;
      total_q <= tally_d;
      full_q  <= full_d;
    end
  end

  assign done_o        = done_q;
  assign bit_value_o   = bit_q;
  assign index_valid_o = valid_q;
  assign found_o       = found_q;
  assign found_index_o = where_q;
  assign set_total_o   = total_q;
  assign full_res_o    = full_q;

  // Checks
  `AFZ_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
  `AFZ_ASSERT_NEXT(a_done_after_run, done_d, done_o && !busy, "result strobe misplaced")
  `AFZ_ASSERT(a_tally_bound, tally_q <= CntW'(MaxSlots), "set tally beyond bitmap size")
  `AFZ_ASSERT(a_found_fields, !(done_o && found_o) || (index_valid_o && !bit_value_o),
              "found result with inconsistent flags")

endmodule
